// File: design/rpn_pkg.sv
// rpn_pkg: shared constants, codes and control types of the RPN stack calculator.
// Used by every module under design/. Depends on nothing.
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int LIST_MAX    = (STACK_DEPTH < MAX_RESULTS) ? STACK_DEPTH : MAX_RESULTS;
	localparam int DIV_CNT_W   = $clog2(DATA_W);

	typedef enum logic [3:0] {
		M_PUSH = 4'd0,
		M_ADD  = 4'd1,
		M_SUB  = 4'd2,
		M_MUL  = 4'd3,
		M_DIV  = 4'd4,
		M_DROP = 4'd5,
		M_SWAP = 4'd6,
		M_DUP  = 4'd7,
		M_LIST = 4'd8
	} mode_t;

	typedef enum logic [1:0] {
		K_ACK   = 2'd0,
		K_ARITH = 2'd1,
		K_LIST  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_DIV0 = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_B,
		S_RD_A,
		S_EXEC,
		S_DIV,
		S_WRES,
		S_SWAP,
		S_ACK,
		S_LIST_RD,
		S_LIST_OUT
	} state_t;

	typedef enum logic [1:0] {
		R_TOP  = 2'd0,
		R_SEC  = 2'd1,
		R_LIDX = 2'd2
	} rsel_t;

	typedef enum logic [1:0] {
		A_CNT = 2'd0,
		A_TOP = 2'd1,
		A_SEC = 2'd2
	} asel_t;

	typedef enum logic [1:0] {
		W_OPND  = 2'd0,
		W_RDATA = 2'd1,
		W_OPB   = 2'd2,
		W_RES   = 2'd3
	} wsel_t;

	typedef struct packed {
		logic    load_in;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    we;
		wsel_t   wsel;
		asel_t   wadr;
		rsel_t   rsel;
		logic    cap_a;
		logic    cap_b;
		logic    set_st;
		status_t st;
		logic    res_ld;
		logic    div_start;
		logic    list_init;
		logic    list_step;
		logic    out_ld;
		kind_t   out_kind;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  empty;
		logic  lt2;
		logic  full;
		logic  b_zero;
		logic  div_done;
		logic  out_free;
		logic  list_last;
	} sts_t;

endpackage

// File: design/rpn_stack_calculator.sv
// rpn_stack_calculator: integer RPN calculator on a 16-entry operand stack, one token per transfer.
// List: after decode, each entry is read, then output once the output register is free.
// One token in flight; next taken on return to idle.
// Reset (arst_n low, asynchronous) empties the stack and clears control; stack contents undefined.
// Depends on rpn_pkg, rpn_ctrl, rpn_dp, rpn_div.
module rpn_stack_calculator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         mode,
	input  logic signed [31:0] operand,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [1:0]         status,
	output logic signed [31:0] value,
	output logic               last
);
	import rpn_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpn_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode_in    (mode),
		.operand_in (operand),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.status     (status),
		.value      (value),
		.last       (last)
	);

endmodule

// File: design/rpn_div.sv
// rpn_div: iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
module rpn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rpn_pkg::DATA_W-1:0] dividend,
	input  logic [rpn_pkg::DATA_W-1:0] divisor,
	output logic                      done,
	output logic [rpn_pkg::DATA_W-1:0] quotient
);
	import rpn_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;
	logic                 neg_q;
	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      diff;
	logic [DATA_W-1:0]    a_mag;
	logic [DATA_W-1:0]    b_mag;

	assign a_mag   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign b_mag   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= a_mag;
			dvs_q <= b_mag;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

// File: design/rpn_dp.sv
// rpn_dp: datapath with operand stack memory, stack count, ALU, list walker and output register.
// Depends on rpn_pkg and rpn_div.
module rpn_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rpn_pkg::cmd_t             cmd,
	output rpn_pkg::sts_t             sts,
	input  logic [3:0]                mode_in,
	input  logic signed [31:0]        operand_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                kind,
	output logic [1:0]                status,
	output logic signed [31:0]        value,
	output logic                      last
);
	import rpn_pkg::*;

	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic [3:0]        mode_q;
	logic [DATA_W-1:0] opnd_q;
	logic [DATA_W-1:0] opa_q;
	logic [DATA_W-1:0] opb_q;
	logic [DATA_W-1:0] res_q;
	status_t           st_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  lidx_q;
	logic [CNT_W-1:0]  lrem_q;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] value_q;
	logic              last_q;

	logic [IDX_W-1:0]  top_idx;
	logic [IDX_W-1:0]  sec_idx;
	logic [IDX_W-1:0]  cnt_idx;
	logic [IDX_W-1:0]  raddr;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] alu;
	logic [DATA_W-1:0] mul_lo;
	logic [DATA_W-1:0] quotient;
	logic              div_done;
	logic              out_free;

	assign top_idx = IDX_W'(cnt_q - CNT_W'(1));
	assign sec_idx = IDX_W'(cnt_q - CNT_W'(2));
	assign cnt_idx = cnt_q[IDX_W-1:0];

	always_comb begin
		case (cmd.rsel)
			R_SEC:   raddr = sec_idx;
			R_LIDX:  raddr = lidx_q;
			default: raddr = top_idx;
		endcase
		case (cmd.wadr)
			A_TOP:   waddr = top_idx;
			A_SEC:   waddr = sec_idx;
			default: waddr = cnt_idx;
		endcase
		case (cmd.wsel)
			W_RDATA: wdata = rdata_q;
			W_OPB:   wdata = opb_q;
			W_RES:   wdata = res_q;
			default: wdata = opnd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (opa_q),
		.divisor  (opb_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign mul_lo = opa_q * opb_q;

	always_comb begin
		case (mode_t'(mode_q))
			M_ADD:   alu = opa_q + opb_q;
			M_SUB:   alu = opa_q - opb_q;
			M_MUL:   alu = mul_lo;
			default: alu = quotient;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= mode_in;
			opnd_q <= operand_in;
		end
		if (cmd.cap_a) begin
			opa_q <= rdata_q;
		end
		if (cmd.cap_b) begin
			opb_q <= rdata_q;
		end
		if (cmd.res_ld) begin
			res_q <= alu;
		end
		if (cmd.set_st) begin
			st_q <= cmd.st;
		end
		if (cmd.list_init) begin
			lidx_q <= top_idx;
			lrem_q <= (cnt_q < CNT_W'(LIST_MAX)) ? cnt_q : CNT_W'(LIST_MAX);
		end else if (cmd.list_step) begin
			lidx_q <= lidx_q - 1'b1;
			lrem_q <= lrem_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			kind_q <= cmd.out_kind;
			case (cmd.out_kind)
				K_ARITH: begin
					status_q <= ST_OK;
					value_q  <= res_q;
					last_q   <= 1'b1;
				end
				K_LIST: begin
					status_q <= ST_OK;
					value_q  <= rdata_q;
					last_q   <= (lrem_q == CNT_W'(1));
				end
				default: begin
					status_q <= st_q;
					value_q  <= '0;
					last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign sts.mode      = mode_t'(mode_q);
	assign sts.empty     = (cnt_q == '0);
	assign sts.lt2       = (cnt_q < CNT_W'(2));
	assign sts.full      = (cnt_q == CNT_W'(STACK_DEPTH));
	assign sts.b_zero    = (opb_q == '0);
	assign sts.div_done  = div_done;
	assign sts.out_free  = out_free;
	assign sts.list_last = (lrem_q == CNT_W'(1));

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign status    = status_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

// File: design/rpn_ctrl.sv
// rpn_ctrl: controller state machine; sequences stack reads, writes, ALU, divider and output.
// Depends on rpn_pkg.
module rpn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rpn_pkg::sts_t sts,
	output rpn_pkg::cmd_t cmd
);
	import rpn_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.rsel   = R_TOP;
				cmd.set_st = 1'b1;
				cmd.st     = ST_OK;
				state_nxt  = S_ACK;
				case (sts.mode)
					M_PUSH: begin
						if (sts.full) begin
							cmd.st = ST_FULL;
						end else begin
							cmd.we      = 1'b1;
							cmd.wsel    = W_OPND;
							cmd.wadr    = A_CNT;
							cmd.cnt_inc = 1'b1;
						end
					end
					M_ADD, M_SUB, M_MUL, M_DIV, M_SWAP: begin
						if (sts.lt2) begin
							cmd.st = ST_FEW;
						end else begin
							state_nxt = S_RD_B;
						end
					end
					M_DROP: begin
						if (sts.empty) begin
							cmd.st = ST_FEW;
						end else begin
							cmd.cnt_dec = 1'b1;
						end
					end
					M_DUP: begin
						if (sts.empty) begin
							cmd.st = ST_FEW;
						end else if (sts.full) begin
							cmd.st = ST_FULL;
						end else begin
							state_nxt = S_RD_B;
						end
					end
					M_LIST: begin
						if (sts.empty) begin
							cmd.st = ST_FEW;
						end else begin
							cmd.list_init = 1'b1;
							state_nxt     = S_LIST_RD;
						end
					end
					default: begin
						cmd.st = ST_OK;
					end
				endcase
			end
			S_RD_B: begin
				cmd.cap_b = 1'b1;
				cmd.rsel  = R_SEC;
				if (sts.mode == M_DUP) begin
					cmd.we      = 1'b1;
					cmd.wsel    = W_RDATA;
					cmd.wadr    = A_CNT;
					cmd.cnt_inc = 1'b1;
					state_nxt   = S_ACK;
				end else begin
					state_nxt = S_RD_A;
				end
			end
			S_RD_A: begin
				cmd.cap_a = 1'b1;
				if (sts.mode == M_SWAP) begin
					cmd.we    = 1'b1;
					cmd.wsel  = W_RDATA;
					cmd.wadr  = A_TOP;
					state_nxt = S_SWAP;
				end else begin
					state_nxt = S_EXEC;
				end
			end
			S_SWAP: begin
				cmd.we    = 1'b1;
				cmd.wsel  = W_OPB;
				cmd.wadr  = A_SEC;
				state_nxt = S_ACK;
			end
			S_EXEC: begin
				if (sts.mode == M_DIV) begin
					if (sts.b_zero) begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_DIV0;
						state_nxt  = S_ACK;
					end else begin
						cmd.div_start = 1'b1;
						state_nxt     = S_DIV;
					end
				end else begin
					cmd.res_ld = 1'b1;
					state_nxt  = S_WRES;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.res_ld = 1'b1;
					state_nxt  = S_WRES;
				end
			end
			S_WRES: begin
				if (sts.out_free) begin
					cmd.we       = 1'b1;
					cmd.wsel     = W_RES;
					cmd.wadr     = A_SEC;
					cmd.cnt_dec  = 1'b1;
					cmd.out_ld   = 1'b1;
					cmd.out_kind = K_ARITH;
					state_nxt    = S_IDLE;
				end
			end
			S_ACK: begin
				if (sts.out_free) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = K_ACK;
					state_nxt    = S_IDLE;
				end
			end
			S_LIST_RD: begin
				cmd.rsel  = R_LIDX;
				state_nxt = S_LIST_OUT;
			end
			S_LIST_OUT: begin
				cmd.rsel = R_LIDX;
				if (sts.out_free) begin
					cmd.out_ld    = 1'b1;
					cmd.out_kind  = K_LIST;
					cmd.list_step = 1'b1;
					state_nxt     = sts.list_last ? S_IDLE : S_LIST_RD;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// File: design/rpn_chk.sv
// rpn_chk: port-level assertions for rpn_stack_calculator, attached by bind.
// Depends on rpn_pkg.
module rpn_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [3:0]         mode,
	input logic signed [31:0] operand,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         kind,
	input logic [1:0]         status,
	input logic signed [31:0] value,
	input logic               last
);
	import rpn_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status)
			&& $stable(value) && $stable(last))
		else $error("result changed while stalled");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_ACK |-> value == '0)
		else $error("acknowledge with nonzero value");

	a_err_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> kind == K_ACK && last)
		else $error("error status on non-acknowledge result");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != K_LIST |-> last)
		else $error("single result without last");

	// one token in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second token taken while busy");

endmodule

bind rpn_stack_calculator rpn_chk u_rpn_chk (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for rpn_stack_calculator, with its own prediction of the stack.
// Valid/ready driver and monitor with random bursts, stalls, long output hold-offs and drains.
// Depends on rpn_pkg and the rpn_stack_calculator RTL.
module tb;
	import rpn_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 12;
	localparam int RAND_TOKENS = 290;
	localparam int HOLD_CYC    = 400;
	localparam int TAIL_CYC    = 64;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic [3:0]  mode;
		logic [31:0] operand;
		bit          wait_idle;
	} token_t;

	typedef struct {
		kind_t       kind;
		status_t     status;
		logic [31:0] value;
		logic        last;
	} result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [3:0]  mode      = '0;
	logic [31:0] operand   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [31:0] value;
	logic        last;

	token_t      pending_tokens[$];
	result_t     expected_results[$];
	logic [31:0] calc_stack[STACK_DEPTH];
	int unsigned calc_depth = 0;
	int unsigned gen_depth  = 0;
	int          errors     = 0;
	int          cycles     = 0;
	int          tx_burst   = 1;
	int          tx_gap     = 0;
	int          rx_left    = 0;
	bit          rx_go      = 1'b1;
	int          hold_cnt   = 0;
	int          result_total = 0;

	rpn_stack_calculator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.operand   (operand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.status    (status),
		.value     (value),
		.last      (last)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void note_result(kind_t k, status_t s, logic [31:0] v, logic l);
		result_t res;
		res.kind   = k;
		res.status = s;
		res.value  = v;
		res.last   = l;
		expected_results.push_back(res);
	endfunction

	// Apply one token to the predicted stack and queue the results it causes.
	function automatic void calc_expect(logic [3:0] m, logic [31:0] opnd);
		logic [31:0] a, b, r;
		longint      sa, sb, q;
		int unsigned n;
		case (m)
			M_PUSH: begin
				if (calc_depth == STACK_DEPTH) begin
					note_result(K_ACK, ST_FULL, '0, 1'b1);
				end else begin
					calc_stack[calc_depth] = opnd;
					calc_depth++;
					note_result(K_ACK, ST_OK, '0, 1'b1);
				end
			end
			M_ADD, M_SUB, M_MUL, M_DIV: begin
				if (calc_depth < 2) begin
					note_result(K_ACK, ST_FEW, '0, 1'b1);
				end else begin
					b = calc_stack[calc_depth - 1];
					a = calc_stack[calc_depth - 2];
					if (m == M_DIV && b == '0) begin
						note_result(K_ACK, ST_DIV0, '0, 1'b1);
					end else begin
						case (m)
							M_ADD: r = a + b;
							M_SUB: r = a - b;
							M_MUL: r = a * b;
							default: begin
								sa = $signed(a);
								sb = $signed(b);
								q  = sa / sb;
								r  = q[31:0];
							end
						endcase
						calc_depth--;
						calc_stack[calc_depth - 1] = r;
						note_result(K_ARITH, ST_OK, r, 1'b1);
					end
				end
			end
			M_DROP: begin
				if (calc_depth == 0) begin
					note_result(K_ACK, ST_FEW, '0, 1'b1);
				end else begin
					calc_depth--;
					note_result(K_ACK, ST_OK, '0, 1'b1);
				end
			end
			M_SWAP: begin
				if (calc_depth < 2) begin
					note_result(K_ACK, ST_FEW, '0, 1'b1);
				end else begin
					a = calc_stack[calc_depth - 1];
					calc_stack[calc_depth - 1] = calc_stack[calc_depth - 2];
					calc_stack[calc_depth - 2] = a;
					note_result(K_ACK, ST_OK, '0, 1'b1);
				end
			end
			M_DUP: begin
				if (calc_depth == 0) begin
					note_result(K_ACK, ST_FEW, '0, 1'b1);
				end else if (calc_depth == STACK_DEPTH) begin
					note_result(K_ACK, ST_FULL, '0, 1'b1);
				end else begin
					calc_stack[calc_depth] = calc_stack[calc_depth - 1];
					calc_depth++;
					note_result(K_ACK, ST_OK, '0, 1'b1);
				end
			end
			M_LIST: begin
				if (calc_depth == 0) begin
					note_result(K_ACK, ST_FEW, '0, 1'b1);
				end else begin
					n = (calc_depth < MAX_RESULTS) ? calc_depth : MAX_RESULTS;
					for (int unsigned i = 0; i < n; i++)
						note_result(K_LIST, ST_OK, calc_stack[calc_depth - 1 - i], i + 1 == n);
				end
			end
			default: note_result(K_ACK, ST_OK, '0, 1'b1);
		endcase
	endfunction

	// Rough depth tracking while building stimulus, only used to steer the mix.
	function automatic void queue_token(logic [3:0] m, logic [31:0] opnd, bit wait_idle);
		token_t tok;
		tok.mode      = m;
		tok.operand   = opnd;
		tok.wait_idle = wait_idle;
		pending_tokens.push_back(tok);
		case (m)
			M_PUSH: if (gen_depth < STACK_DEPTH) gen_depth++;
			M_ADD, M_SUB, M_MUL, M_DIV, M_DROP: begin
				if (gen_depth >= ((m == M_DROP) ? 1 : 2))
					gen_depth--;
			end
			M_DUP: if (gen_depth > 0 && gen_depth < STACK_DEPTH) gen_depth++;
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'($urandom_range(0, 9));
			1: return -32'($urandom_range(1, 9));
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return '0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// Driver: offers queued tokens in bursts; a wait_idle token is held until all results are in.
	always @(posedge clk or negedge arst_n) begin : drv
		token_t tok;
		logic   offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode     <= '0;
			operand  <= '0;
			tx_burst <= 1;
			tx_gap   <= 0;
		end else begin
			if (in_valid && in_ready)
				calc_expect(mode, operand);
			if (!in_valid || in_ready) begin
				offer = 1'b0;
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
				end else if (pending_tokens.size() != 0 &&
					!(pending_tokens[0].wait_idle && expected_results.size() != 0)) begin
					tok     = pending_tokens.pop_front();
					mode    <= tok.mode;
					operand <= tok.operand;
					offer   = 1'b1;
					if (tx_burst <= 1) begin
						tx_burst <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
						tx_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						tx_burst <= tx_burst - 1;
					end
				end
				in_valid <= offer;
			end
		end
	end

	// Monitor: checks each transfer against the oldest prediction and paces out_ready.
	always @(posedge clk or negedge arst_n) begin : mon
		result_t res;
		logic    rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected transfer: kind %0d status %0d value %0d last %0d",
						kind, status, $signed(value), last);
					errors++;
				end else begin
					res = expected_results.pop_front();
					if (kind !== res.kind) begin
						$error("kind: expected %0d, actual %0d", res.kind, kind);
						errors++;
					end
					if (status !== res.status) begin
						$error("status: expected %0d, actual %0d", res.status, status);
						errors++;
					end
					if (value !== res.value) begin
						$error("value: expected %0d, actual %0d",
							$signed(res.value), $signed(value));
						errors++;
					end
					if (last !== res.last) begin
						$error("last: expected %0d, actual %0d", res.last, last);
						errors++;
					end
				end
				result_total++;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				rdy = 1'b0;
			end else if (out_valid && out_ready && (result_total == 120 || result_total == 400)) begin
				// long hold-off so the block backs up and stalls its input
				hold_cnt = HOLD_CYC;
				rdy = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_go   = ($urandom_range(0, 3) != 0);
					rx_left = rx_go ? $urandom_range(1, 40) : $urandom_range(1, 8);
				end
				rx_left--;
				rdy = rx_go;
			end
			out_ready <= rdy;
		end
	end

	initial begin : stim
		logic [3:0] m;
		int         r;
		bit         climb;
		bit         idle_next;

		// error paths on an empty and a one-entry stack, then an add that wraps to the most negative value
		queue_token(M_LIST, '0, 1'b0);
		queue_token(M_DROP, '0, 1'b0);
		queue_token(M_DUP,  '0, 1'b0);
		queue_token(M_SWAP, '0, 1'b0);
		queue_token(M_ADD,  '0, 1'b0);
		queue_token(M_PUSH, 32'h7FFF_FFFF, 1'b0);
		queue_token(M_SUB,  32'hFFFF_FFFF, 1'b0);
		queue_token(M_PUSH, 32'h0000_0001, 1'b0);
		queue_token(M_ADD,  '0, 1'b0);
		// most negative divided by -1 wraps
		queue_token(M_PUSH, 32'hFFFF_FFFF, 1'b0);
		queue_token(M_DIV,  '0, 1'b0);
		queue_token(M_PUSH, '0, 1'b0);
		queue_token(M_DIV,  '0, 1'b0);
		queue_token(4'd9,   32'h5A5A_5A5A, 1'b0);
		queue_token(4'd15,  32'hFFFF_FFFF, 1'b0);
		queue_token(M_PUSH, 32'd5, 1'b0);
		queue_token(M_SWAP, '0, 1'b0);
		queue_token(M_DUP,  '0, 1'b0);
		queue_token(M_MUL,  '0, 1'b0);
		queue_token(M_SUB,  '0, 1'b0);
		queue_token(M_LIST, '0, 1'b0);
		queue_token(M_DROP, '0, 1'b0);
		// fill to the top, then overflow attempts and a full listing
		while (gen_depth < STACK_DEPTH)
			queue_token(M_PUSH, rand_operand(), 1'b0);
		queue_token(M_PUSH, rand_operand(), 1'b0);
		queue_token(M_DUP,  '0, 1'b0);
		queue_token(M_LIST, '0, 1'b0);

		climb     = 1'b1;
		idle_next = 1'b1;
		for (int i = 0; i < RAND_TOKENS; i++) begin
			if ($urandom_range(0, 19) == 0)
				climb = !climb;
			r = $urandom_range(0, 99);
			if (r < (climb ? 50 : 22) || (gen_depth < 2 && r < 75))
				m = M_PUSH;
			else if (r < 58)
				m = 4'($urandom_range(M_ADD, M_DIV));
			else if (r < 66)
				m = M_DROP;
			else if (r < 73)
				m = M_SWAP;
			else if (r < 80)
				m = M_DUP;
			else if (r < 87)
				m = M_LIST;
			else if (r < 91)
				m = 4'($urandom_range(9, 15));
			else begin
				queue_token(M_PUSH, '0, idle_next);
				idle_next = 1'b0;
				m = M_DIV;
			end
			queue_token(m, rand_operand(), idle_next);
			idle_next = (i % 60 == 59);
		end

		while (pending_tokens.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
